FILE: rtl/trial_division_prime_test_macros.svh
// Assertion macros shared by the trial division prime test checkers
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TDP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define TDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tdp_pkg.sv
// Shared widths, types and constants of the trial division prime test
package tdp_pkg;

    localparam int VALUE_BITS = 31;
    localparam int DIV_W      = VALUE_BITS / 2 + 2;
    localparam int SQ_W       = VALUE_BITS + 1;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [DIV_W-1:0]      div_t;
    typedef logic [SQ_W-1:0]       sq_t;

    localparam div_t FIRST_DIV = DIV_W'(3);
    localparam sq_t  FIRST_SQ  = SQ_W'(9);

    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

FILE: rtl/tdp_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle
module tdp_rem (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  tdp_pkg::value_t      dividend,
    input  tdp_pkg::div_t        divisor,
    output tdp_pkg::rem_status_t status
);
    import tdp_pkg::*;

    value_t           sh_reg, sh_next;
    logic [DIV_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        sh_next     = sh_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        trial       = {rem_reg[DIV_W-1:0], sh_reg[VALUE_BITS-1]};
        if (go)
        begin
            sh_next     = dividend;
            rem_next    = '0;
            cnt_next    = CNT_W'(VALUE_BITS);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            sh_next = {sh_reg[VALUE_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

FILE: rtl/tdp_sqr.sv
// Odd trial divisor and its square, stepped by two
module tdp_sqr (
    input  logic          clk,
    input  logic          init,
    input  logic          adv,
    output tdp_pkg::div_t div,
    output tdp_pkg::sq_t  sq
);
    import tdp_pkg::*;

    div_t div_reg, div_next;
    sq_t  sq_reg, sq_next;

    always_comb
    begin
        div_next = div_reg;
        sq_next  = sq_reg;
        if (init)
        begin
            div_next = FIRST_DIV;
            sq_next  = FIRST_SQ;
        end
        else if (adv)
        begin
            div_next = div_reg + DIV_W'(2);
            sq_next  = sq_reg + SQ_W'({div_reg, 2'b00}) + SQ_W'(4);
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        sq_reg  <= sq_next;
    end

    assign div = div_reg;
    assign sq  = sq_reg;

endmodule

FILE: rtl/trial_division_prime_test.sv
// Top level of the trial division prime test
//
// Raise start with a candidate while busy is low; the candidate is
// transferred at that clock edge and busy rises on the next cycle.
// One result follows: done pulses high for one cycle with
// is_prime_flag valid, in the same cycle busy falls. A new start may
// be given in that cycle. The receiver cannot hold results off.
// Candidates below four and even values are decided in ST_CLASS.
// Odd candidates try divisors 3, 5, 7, ... while the divisor squared
// stays at most the candidate; each divisor is tested in the
// bit-serial remainder unit, one dividend bit a cycle. Items are
// taken one at a time.
// Reset (rst_n low) drops any item in flight and returns to idle with
// busy and done low.
module trial_division_prime_test (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tdp_pkg::value_t candidate,
    output logic            busy,
    output logic            done,
    output logic            is_prime_flag
);
    import tdp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLASS = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;

    logic [2:0]  state_reg, state_next;
    value_t      n_reg, n_next;
    logic        done_reg, done_next;
    logic        flag_reg, flag_next;
    logic        rem_go, sq_init, sq_adv;
    div_t        div;
    sq_t         sq;
    rem_status_t rem_st;

    tdp_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (rem_go),
        .dividend (n_reg),
        .divisor  (div),
        .status   (rem_st)
    );

    tdp_sqr u_sqr (
        .clk  (clk),
        .init (sq_init),
        .adv  (sq_adv),
        .div  (div),
        .sq   (sq)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        done_next  = 1'b0;
        flag_next  = flag_reg;
        rem_go     = 1'b0;
        sq_init    = 1'b0;
        sq_adv     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = candidate;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                if (n_reg inside {VALUE_BITS'(0), VALUE_BITS'(1)})
                begin
                    flag_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (n_reg inside {VALUE_BITS'(2), VALUE_BITS'(3)})
                begin
                    flag_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!n_reg[0])
                begin
                    flag_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sq_init    = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sq > {1'b0, n_reg})
                begin
                    flag_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rem_go     = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (rem_st.done)
                begin
                    if (rem_st.zero)
                    begin
                        flag_next  = 1'b0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sq_adv     = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        flag_reg <= flag_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign is_prime_flag = flag_reg;

endmodule

FILE: rtl/tdp_checker.sv
// Port-level checks of the trial division prime test, bound to the top level
`include "trial_division_prime_test_macros.svh"

module tdp_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    `TDP_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "done while busy")
    `TDP_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "transfer did not raise busy")
    `TDP_ASSERT_NOW(a_fall_done, clk, rst_n, $fell(busy), done, "busy fell without a result")
    `TDP_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done held over two cycles")

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (.*);
